// ===== rtl/core/lstk_pkg.sv =====
// Shared types for the bounded LIFO stack: request kinds, result status codes
// and the control struct passed from the request decoder to the top level.
// No dependencies.
`default_nettype none

package lstk_pkg;

	typedef enum logic [2:0] {
		OP_PUSH      = 3'd0,
		OP_POP       = 3'd1,
		OP_PEEK_TOP3 = 3'd2,
		OP_PEEK_BOT3 = 3'd3,
		OP_POPN      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic    wr_en;   // write push word at addr
		logic    rd_en;   // read entry at addr, return it
		logic    cnt_en;  // load new count
		status_t status;
	} ctrl_t;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned NPOP_W   = 5;
	localparam int unsigned OCC_W    = 5;
	localparam int unsigned BOT3_IDX = 2;
	localparam int unsigned PEEK_MIN = 3;

endpackage

`default_nettype wire

// ===== rtl/core/bounded_stack_with_peek_and_multipop.sv =====
// Top level of the bounded LIFO stack: entry memory, count register and
// result register. Uses lstk_pkg and lstk_ctrl.
//
// Usage:
//   Requests come in on the s_ group, one word per handshake: s_tuser holds
//   the request kind, s_tdata the push word and the pop n count. Every
//   request gives exactly one result word on the m_ group: the popped or
//   peeked value (zero otherwise), a status and the occupancy after the
//   request.
//   The result of a request is loaded into the output register at the edge
//   that accepts it. Throughput is one request per cycle while the receiver
//   takes results; the entry memory has one port, and each request makes at
//   most one access to it (a push write or a pop/peek read).
//   The output register parts the two sides: s_tready is high while the
//   output register is empty or its word is being taken, so a stalled
//   receiver holds one finished result and stops new requests behind it.
//   Reset empties the stack and the output register; entry contents are
//   not cleared, and no read ever reaches an entry below the count that
//   was not written.
`default_nettype none

module bounded_stack_with_peek_and_multipop #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] push_value, [36:32] pop_count, rest zero
	input  wire logic [2:0]  s_tuser,   // [2:0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // [31:0] read_value, [33:32] status,
	                                    // [38:34] occupancy, rest zero
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = $clog2(DEPTH);

	// request fields
	lstk_pkg::op_t                   op;
	logic [lstk_pkg::WORD_W-1:0]     push_value;
	logic [lstk_pkg::NPOP_W-1:0]     pop_count;
	logic                            acc;

	// decoder outputs
	lstk_pkg::ctrl_t                 ctrl;
	logic [AW-1:0]                   addr;
	logic [CW-1:0]                   count_nxt;

	// state
	logic [CW-1:0]                   count_q;
	logic [lstk_pkg::WORD_W-1:0]     mem [DEPTH];

	// result register
	logic                            vld_s1;
	logic                            rd_s1;
	lstk_pkg::status_t               st_s1;
	logic [lstk_pkg::OCC_W-1:0]      occ_s1;
	logic [lstk_pkg::WORD_W-1:0]     data_s1;
	logic [lstk_pkg::WORD_W-1:0]     read_value;

	assign op         = lstk_pkg::op_t'(s_tuser[lstk_pkg::OP_W-1:0]);
	assign push_value = s_tdata[lstk_pkg::WORD_W-1:0];
	assign pop_count  = s_tdata[lstk_pkg::WORD_W +: lstk_pkg::NPOP_W];

	// take a new word whenever the result register is free or draining
	assign s_tready = !vld_s1 || m_tready;
	assign acc      = s_tvalid && s_tready;

	lstk_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.op       (op),
		.pop_count(pop_count),
		.count    (count_q),
		.ctrl     (ctrl),
		.addr     (addr),
		.count_nxt(count_nxt)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (acc && ctrl.cnt_en) begin
				count_q <= count_nxt;
			end
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (m_tready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// result payload, loaded only on accept so a stalled word holds
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1  <= ctrl.rd_en;
			st_s1  <= ctrl.status;
			occ_s1 <= lstk_pkg::OCC_W'(count_nxt);
		end
	end

	// entry memory: at most one access per request, registered read
	always_ff @(posedge clk) begin
		if (acc && ctrl.wr_en) begin
			mem[addr] <= push_value;
		end
		if (acc && ctrl.rd_en) begin
			data_s1 <= mem[addr];
		end
	end

	assign read_value = rd_s1 ? data_s1 : '0;
	assign m_tvalid   = vld_s1;
	assign m_tdata    = {1'b0, occ_s1, st_s1, read_value};

	// count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack count beyond depth");

	// a full push reports overflow and leaves the count alone
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == lstk_pkg::OP_PUSH && count_q == CW'(DEPTH))
		|=> (st_s1 == lstk_pkg::ST_OVERFLOW && $stable(count_q)))
		else $error("full push did not report overflow");

	// an underflowing request keeps the count
	a_underflow_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && ctrl.status == lstk_pkg::ST_UNDERFLOW) |=> $stable(count_q))
		else $error("count changed on underflow");

	// a good pop takes exactly one entry and returns a read word
	a_pop_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == lstk_pkg::OP_POP && count_q != '0)
		|=> (count_q == $past(count_q) - CW'(1) && rd_s1))
		else $error("pop did not drop one entry");

	// occupancy in the result matches the live count when it is shown fresh
	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (occ_s1 == lstk_pkg::OCC_W'(count_q)))
		else $error("result occupancy differs from count");

endmodule

`default_nettype wire

// ===== rtl/core/lstk_ctrl.sv =====
// Request decoder for the LIFO stack: checks a request against the current
// count and gives memory access, new count and status. Uses lstk_pkg.
`default_nettype none

module lstk_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  wire lstk_pkg::op_t                      op,
	input  wire logic [lstk_pkg::NPOP_W-1:0]        pop_count,
	input  wire logic [$clog2(DEPTH+1)-1:0]         count,
	output lstk_pkg::ctrl_t                         ctrl,
	output logic [$clog2(DEPTH)-1:0]                addr,
	output logic [$clog2(DEPTH+1)-1:0]              count_nxt
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = $clog2(DEPTH);
	// compare width for pop n: wide enough for count and pop_count
	localparam int unsigned NW = (CW > lstk_pkg::NPOP_W) ? CW : lstk_pkg::NPOP_W;

	logic [NW-1:0] cnt_ext;
	logic [NW-1:0] n_ext;
	logic          few3;

	assign cnt_ext = NW'(count);
	assign n_ext   = NW'(pop_count);
	assign few3    = (count < CW'(lstk_pkg::PEEK_MIN));

	always_comb begin
		ctrl.wr_en  = 1'b0;
		ctrl.rd_en  = 1'b0;
		ctrl.cnt_en = 1'b0;
		ctrl.status = lstk_pkg::ST_OK;
		addr        = AW'(count);
		count_nxt   = count;
		unique case (op)
			lstk_pkg::OP_PUSH: begin
				if (count == CW'(DEPTH)) begin
					ctrl.status = lstk_pkg::ST_OVERFLOW;
				end else begin
					ctrl.wr_en  = 1'b1;
					ctrl.cnt_en = 1'b1;
					count_nxt   = count + CW'(1);
				end
			end
			lstk_pkg::OP_POP: begin
				if (count == '0) begin
					ctrl.status = lstk_pkg::ST_UNDERFLOW;
				end else begin
					ctrl.rd_en  = 1'b1;
					ctrl.cnt_en = 1'b1;
					count_nxt   = count - CW'(1);
					addr        = AW'(count - CW'(1));
				end
			end
			lstk_pkg::OP_PEEK_TOP3: begin
				if (few3) begin
					ctrl.status = lstk_pkg::ST_UNDERFLOW;
				end else begin
					ctrl.rd_en = 1'b1;
					addr       = AW'(count - CW'(lstk_pkg::PEEK_MIN));
				end
			end
			lstk_pkg::OP_PEEK_BOT3: begin
				if (few3) begin
					ctrl.status = lstk_pkg::ST_UNDERFLOW;
				end else begin
					ctrl.rd_en = 1'b1;
					addr       = AW'(lstk_pkg::BOT3_IDX);
				end
			end
			lstk_pkg::OP_POPN: begin
				if (n_ext > cnt_ext) begin
					ctrl.status = lstk_pkg::ST_UNDERFLOW;
				end else begin
					ctrl.cnt_en = 1'b1;
					count_nxt   = CW'(cnt_ext - n_ext);
				end
			end
			default: begin
				// unknown request: no effect, ok status
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== verif/tb_bounded_stack_with_peek_and_multipop.sv =====
// Testbench for bounded_stack_with_peek_and_multipop: directed corner words, a
// backpressure flood and random push/pop/peek traffic, checked by a shadow stack.
// Depends on lstk_pkg and the stack RTL.
`default_nettype none

module tb_bounded_stack_with_peek_and_multipop;

	localparam int unsigned STACK_DEPTH        = 16;
	localparam int unsigned TOTAL_WORDS        = 1550;
	localparam int unsigned QUIET_TAIL         = 200;  // last words run with no idling
	localparam int unsigned HOLD_CYCLES        = 64;   // long receiver stall
	localparam int unsigned STALL_LIMIT        = 2000; // cycles with no handshake at all

	// request kinds the block does not know; it answers them without change
	localparam logic [lstk_pkg::OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
	localparam logic [lstk_pkg::OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;

	typedef struct packed {
		logic [lstk_pkg::WORD_W-1:0] value;
		lstk_pkg::status_t           status;
		logic [lstk_pkg::OCC_W-1:0]  occupancy;
	} stack_result_t;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	// Shadow copy of the stack; predicts one result per accepted request.
	class stack_scoreboard;
		logic [lstk_pkg::WORD_W-1:0] entries [STACK_DEPTH];
		int unsigned                 held;
		stack_result_t               awaited [$];
		int unsigned                 errors;

		function new();
			held   = 0;
			errors = 0;
		endfunction

		function void note_request(logic [lstk_pkg::OP_W-1:0] kind,
				logic [lstk_pkg::WORD_W-1:0] word, logic [lstk_pkg::NPOP_W-1:0] n);
			stack_result_t r;
			r.value  = '0;
			r.status = lstk_pkg::ST_OK;
			case (kind)
				lstk_pkg::OP_PUSH: begin
					if (held == STACK_DEPTH) begin
						r.status = lstk_pkg::ST_OVERFLOW;
					end else begin
						entries[held] = word;
						held++;
					end
				end
				lstk_pkg::OP_POP: begin
					if (held == 0) begin
						r.status = lstk_pkg::ST_UNDERFLOW;
					end else begin
						held--;
						r.value = entries[held];
					end
				end
				lstk_pkg::OP_PEEK_TOP3: begin
					if (held < lstk_pkg::PEEK_MIN)
						r.status = lstk_pkg::ST_UNDERFLOW;
					else
						r.value = entries[held - lstk_pkg::PEEK_MIN];
				end
				lstk_pkg::OP_PEEK_BOT3: begin
					if (held < lstk_pkg::PEEK_MIN)
						r.status = lstk_pkg::ST_UNDERFLOW;
					else
						r.value = entries[lstk_pkg::BOT3_IDX];
				end
				lstk_pkg::OP_POPN: begin
					if (n > held)
						r.status = lstk_pkg::ST_UNDERFLOW;
					else
						held -= n;
				end
				default: ;
			endcase
			r.occupancy = lstk_pkg::OCC_W'(held);
			awaited.push_back(r);
		endfunction

		function void check_result(logic [39:0] word);
			stack_result_t               want;
			logic [lstk_pkg::WORD_W-1:0] got_value;
			logic [1:0]                  got_status;
			logic [lstk_pkg::OCC_W-1:0]  got_occ;
			logic                        got_pad;
			got_value  = word[31:0];
			got_status = word[33:32];
			got_occ    = word[38:34];
			got_pad    = word[39];
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: value %h status %0d occ %0d",
					$time, got_value, got_status, got_occ);
				return;
			end
			want = awaited.pop_front();
			if (got_value !== want.value || got_status !== want.status ||
					got_occ !== want.occupancy || got_pad !== 1'b0) begin
				errors++;
				$display("%0t: mismatch: expected %h/%0d/%0d, got %h/%0d/%0d pad %b",
					$time, want.value, want.status, want.occupancy,
					got_value, got_status, got_occ, got_pad);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [31:0] push_value, [36:32] pop_count, rest zero
	logic [2:0]  s_tuser;   // [2:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] read_value, [33:32] status, [38:34] occupancy

	stack_scoreboard sb;
	bit              tx_gaps;
	bit              rx_gaps;
	bit              hold_req;
	int unsigned     sent_words;
	int unsigned     idle_cycles;

	bounded_stack_with_peek_and_multipop #(
		.DEPTH(STACK_DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Handshakes are sampled right after the edge, before any NBA lands, so
	// every read sees the values the block saw at that edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[31:0], s_tdata[36:32]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus one long hold on request from the sender.
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offers one request word and returns at the edge that takes it.
	task automatic send_word(input logic [lstk_pkg::OP_W-1:0] kind,
			input logic [lstk_pkg::WORD_W-1:0] word,
			input logic [lstk_pkg::NPOP_W-1:0] n);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, n, word};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind <= lstk_pkg::OP_POPN)
			sent_words++;
	endtask

	// Sender pause: nothing offered until every predicted result is back.
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic random_word(input traffic_mode_t mode);
		logic [lstk_pkg::OP_W-1:0]   kind;
		logic [lstk_pkg::WORD_W-1:0] word;
		logic [lstk_pkg::NPOP_W-1:0] n;
		int unsigned                 roll;
		int unsigned                 push_pct;
		int unsigned                 pop_pct;
		int unsigned                 popn_pct;
		case (mode)
			MODE_FILL:  begin push_pct = 60; pop_pct = 10; popn_pct = 5;  end
			MODE_DRAIN: begin push_pct = 10; pop_pct = 35; popn_pct = 25; end
			default:    begin push_pct = 30; pop_pct = 25; popn_pct = 15; end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < 3)
			kind = lstk_pkg::OP_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
		else begin
			roll = $urandom_range(0, 99);
			if (roll < push_pct)
				kind = lstk_pkg::OP_PUSH;
			else if (roll < push_pct + pop_pct)
				kind = lstk_pkg::OP_POP;
			else if (roll < push_pct + pop_pct + popn_pct)
				kind = lstk_pkg::OP_POPN;
			else if (roll[0])
				kind = lstk_pkg::OP_PEEK_TOP3;
			else
				kind = lstk_pkg::OP_PEEK_BOT3;
		end
		// extreme words now and then, full random otherwise
		case ($urandom_range(0, 19))
			0:       word = 32'h8000_0000;
			1:       word = 32'h7FFF_FFFF;
			2:       word = 32'hFFFF_FFFF;
			3:       word = '0;
			default: word = $urandom;
		endcase
		// pop n mostly within the occupancy, sometimes past it
		roll = $urandom_range(0, 9);
		if (roll < 8)
			n = lstk_pkg::NPOP_W'($urandom_range(0, sb.held));
		else if (roll == 8)
			n = lstk_pkg::NPOP_W'($urandom_range(sb.held + 1, 31));
		else
			n = lstk_pkg::NPOP_W'($urandom);
		send_word(kind, word, n);
	endtask

	initial begin
		traffic_mode_t mode;
		int unsigned   mode_left;
		sb         = new();
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		tx_gaps    = 1'b1;
		rx_gaps    = 1'b1;
		hold_req   = 1'b0;
		sent_words = 0;
		idle_cycles = 0;
		mode       = MODE_MIXED;
		mode_left  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack: every read kind fails, pop n of zero succeeds
		send_word(lstk_pkg::OP_POP,       '0, '0);
		send_word(lstk_pkg::OP_PEEK_TOP3, '0, '0);
		send_word(lstk_pkg::OP_PEEK_BOT3, '0, '0);
		send_word(lstk_pkg::OP_POPN,      '0, 5'd1);
		send_word(lstk_pkg::OP_POPN,      '0, '0);
		// unknown kinds, push word and pop count bits all high
		send_word(OP_UNKNOWN_FIRST,                  32'hFFFF_FFFF, 5'd31);
		send_word(OP_UNKNOWN_FIRST + lstk_pkg::OP_W'(1), 32'hFFFF_FFFF, 5'd31);
		send_word(OP_UNKNOWN_LAST,                   32'hFFFF_FFFF, 5'd31);
		send_word(lstk_pkg::OP_PUSH, 32'h8000_0000, 5'd31);
		send_word(lstk_pkg::OP_PUSH, 32'h7FFF_FFFF, '0);
		send_word(lstk_pkg::OP_PEEK_TOP3, '0, '0);          // two entries: too few
		send_word(lstk_pkg::OP_PEEK_BOT3, '0, '0);
		send_word(lstk_pkg::OP_PUSH, 32'hFFFF_FFFF, '0);
		send_word(lstk_pkg::OP_PEEK_TOP3, '0, '0);          // exactly three entries
		send_word(lstk_pkg::OP_PEEK_BOT3, '0, '0);
		send_word(lstk_pkg::OP_PUSH, '0, '0);
		send_word(lstk_pkg::OP_PEEK_TOP3, '0, '0);
		send_word(lstk_pkg::OP_POPN, '0, 5'd5);             // past occupancy
		send_word(lstk_pkg::OP_POP,  '0, '0);
		send_word(lstk_pkg::OP_POPN, '0, 5'd3);             // down to empty
		send_word(lstk_pkg::OP_PUSH, 32'h0000_0001, '0);
		send_word(lstk_pkg::OP_POP,  '0, '0);
		wait_all_results();

		// receiver holds off while the sender keeps pushing past full
		hold_req = 1'b1;
		repeat (STACK_DEPTH + 4) send_word(lstk_pkg::OP_PUSH, $urandom, '0);
		send_word(lstk_pkg::OP_PEEK_TOP3, '0, '0);
		send_word(lstk_pkg::OP_PEEK_BOT3, '0, '0);
		send_word(lstk_pkg::OP_POPN, '0, 5'd31);
		send_word(lstk_pkg::OP_POPN, '0, 5'(STACK_DEPTH));
		send_word(lstk_pkg::OP_POP,  '0, '0);
		wait_all_results();

		while (sent_words < TOTAL_WORDS) begin
			if (mode_left == 0) begin
				mode      = traffic_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(10, 50);
			end
			mode_left--;
			if (sent_words >= TOTAL_WORDS - QUIET_TAIL) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			random_word(mode);
		end

		wait_all_results();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
